@@ design/ims_pkg.sv @@
// Shared constants and types for the in-place merge sorter.
package ims_pkg;
    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS,
        ST_RUN,
        ST_RD_I,
        ST_RD_J,
        ST_CMP,
        ST_FLIP_RD,
        ST_FLIP_WR,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    function automatic logic is_less(input logic signed [31:0] a, input logic signed [31:0] b);
        is_less = a < b;
    endfunction
endpackage

@@ design/inplace_merge_sorter.sv @@
// Top level: load, bottom-up rotation merge sort, and emit.
// Loading takes one cycle per request; non-final requests give no result.
// The sort reads or writes one buffer entry per cycle through one memory port
// pair; the results of a set then leave in ascending order, each read in ST_EMIT_RD
// and issued in ST_EMIT while not stalled; requests stall meanwhile.
// Reset (rst_n low, asynchronous) empties the set and returns to loading.
module inplace_merge_sorter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sorted_value,
    output logic               end_of_set
);
    localparam int CW = ims_pkg::CW;
    localparam int AW = ims_pkg::AW;

    ims_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0] n_reg, n_next, w_reg, w_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, st_reg, st_next;
    logic [CW-1:0] fa_reg, fa_next, fb_reg, fb_next;
    logic [1:0]    ph_reg, ph_next, rp_reg, rp_next;
    logic [31:0]   vi_reg, vi_next, t_reg, t_next, oval_reg, oval_next;
    logic          oe_reg, oe_next, ov_reg, ov_next;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;
    logic [CW:0]   two_w, lo_w;

    ims_store u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ims_pkg::ST_LOAD;
            ret_reg   <= ims_pkg::ST_LOAD;
            n_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            n_reg     <= n_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next; lo_reg <= lo_next; hi_reg <= hi_next;
        i_reg <= i_next; j_reg <= j_next; st_reg <= st_next;
        fa_reg <= fa_next; fb_reg <= fb_next; ph_reg <= ph_next; rp_reg <= rp_next;
        vi_reg <= vi_next; t_reg <= t_next; oval_reg <= oval_next; oe_reg <= oe_next;
    end

    assign in_stall     = (state_reg != ims_pkg::ST_LOAD);
    assign out_valid    = ov_reg;
    assign sorted_value = oval_reg;
    assign end_of_set   = oe_reg;
    assign two_w        = {w_reg, 1'b0};
    assign lo_w         = {1'b0, lo_reg} + {1'b0, w_reg};

    always_comb
    begin
        state_next = state_reg; ret_next = ret_reg; n_next = n_reg; w_next = w_reg;
        lo_next = lo_reg; hi_next = hi_reg; i_next = i_reg; j_next = j_reg;
        st_next = st_reg; fa_next = fa_reg; fb_next = fb_reg; ph_next = ph_reg;
        rp_next = rp_reg; vi_next = vi_reg; t_next = t_reg; oval_next = oval_reg;
        oe_next = oe_reg; ov_next = ov_reg;
        we = 1'b0; waddr = n_reg[AW-1:0]; wdata = value; raddr = '0;
        case (state_reg)
            ims_pkg::ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (n_reg < CW'(ims_pkg::DEPTH))
                    begin
                        we = 1'b1;
                        n_next = n_reg + 1'b1;
                    end
                    if (last)
                    begin
                        w_next = CW'(1);
                        lo_next = '0;
                        state_next = ims_pkg::ST_PASS;
                    end
                end
            end
            ims_pkg::ST_PASS:
            begin
                if (w_reg < n_reg)
                begin
                    lo_next = '0;
                    state_next = ims_pkg::ST_RUN;
                end
                else
                begin
                    i_next = '0;
                    state_next = ims_pkg::ST_EMIT_RD;
                end
            end
            ims_pkg::ST_RUN:
            begin
                if (lo_w < {1'b0, n_reg})
                begin
                    i_next = lo_reg;
                    j_next = lo_w[CW-1:0];
                    hi_next = ({1'b0, lo_reg} + two_w > {1'b0, n_reg}) ? n_reg
                            : CW'({1'b0, lo_reg} + two_w);
                    lo_next = CW'({1'b0, lo_reg} + two_w);
                    ph_next = 2'd0;
                    state_next = ims_pkg::ST_RD_I;
                end
                else
                begin
                    w_next = CW'(two_w);
                    state_next = ims_pkg::ST_PASS;
                end
            end
            ims_pkg::ST_RD_I:
            begin
                if (i_reg < j_reg && j_reg < hi_reg)
                begin
                    raddr = i_reg[AW-1:0];
                    if (ph_reg == 2'd0) st_next = j_reg;
                    state_next = ims_pkg::ST_RD_J;
                end
                else if (ph_reg == 2'd1)
                begin
                    // j scan ended: rotate
                    fa_next = i_reg; fb_next = st_reg; rp_next = 2'd0;
                    state_next = ims_pkg::ST_FLIP_RD;
                end
                else if (ph_reg == 2'd0 && i_reg < j_reg && j_reg >= hi_reg)
                begin
                    state_next = ims_pkg::ST_RUN;
                end
                else
                begin
                    state_next = ims_pkg::ST_RUN;
                end
            end
            ims_pkg::ST_RD_J:
            begin
                vi_next = rdata;
                raddr = j_reg[AW-1:0];
                state_next = ims_pkg::ST_CMP;
            end
            ims_pkg::ST_CMP:
            begin
                if (ph_reg == 2'd0)
                begin
                    if (!ims_pkg::is_less(rdata, vi_reg))
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = ims_pkg::ST_RD_I;
                    end
                    else
                    begin
                        ph_next = 2'd1;
                        j_next = j_reg + 1'b1;
                        state_next = ims_pkg::ST_RD_I;
                    end
                end
                else if (ims_pkg::is_less(rdata, vi_reg))
                begin
                    j_next = j_reg + 1'b1;
                    state_next = ims_pkg::ST_RD_I;
                end
                else
                begin
                    fa_next = i_reg; fb_next = st_reg; rp_next = 2'd0;
                    state_next = ims_pkg::ST_FLIP_RD;
                end
            end
            ims_pkg::ST_FLIP_RD:
            begin
                if (fa_reg + 1'b1 < fb_reg)
                begin
                    raddr = fa_reg[AW-1:0];
                    state_next = ims_pkg::ST_FLIP_WR;
                    ph_next = 2'd2;
                end
                else if (rp_reg == 2'd0)
                begin
                    fa_next = st_reg; fb_next = j_reg; rp_next = 2'd1;
                end
                else if (rp_reg == 2'd1)
                begin
                    fa_next = i_reg; fb_next = j_reg; rp_next = 2'd2;
                end
                else
                begin
                    i_next = CW'(i_reg + j_reg - st_reg);
                    ph_next = 2'd0;
                    state_next = ims_pkg::ST_RD_I;
                end
            end
            ims_pkg::ST_FLIP_WR:
            begin
                if (ph_reg == 2'd2)
                begin
                    t_next = rdata;
                    raddr = AW'(fb_reg - 1'b1);
                    ph_next = 2'd3;
                end
                else
                begin
                    we = 1'b1; waddr = fa_reg[AW-1:0]; wdata = rdata;
                    ph_next = 2'd0;
                    state_next = ims_pkg::ST_EMIT;
                    ret_next = ims_pkg::ST_FLIP_RD;
                end
            end
            ims_pkg::ST_EMIT_RD:
            begin
                raddr = i_reg[AW-1:0];
                if (!ov_reg || !out_stall) ov_next = 1'b0;
                if (!ov_reg || !out_stall)
                begin
                    ret_next = ims_pkg::ST_EMIT_RD;
                    state_next = ims_pkg::ST_EMIT;
                end
            end
            ims_pkg::ST_EMIT:
            begin
                if (ret_reg == ims_pkg::ST_FLIP_RD)
                begin
                    // second half of swap
                    we = 1'b1; waddr = AW'(fb_reg - 1'b1); wdata = t_reg;
                    fa_next = fa_reg + 1'b1; fb_next = fb_reg - 1'b1;
                    state_next = ims_pkg::ST_FLIP_RD;
                end
                else
                begin
                    oval_next = rdata;
                    oe_next = (i_reg + 1'b1 == n_reg);
                    ov_next = 1'b1;
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        n_next = '0;
                        state_next = ims_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = ims_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ims_pkg::ST_LOAD;
        endcase
        if (ov_reg && !out_stall && !(state_reg == ims_pkg::ST_EMIT
            && ret_reg == ims_pkg::ST_EMIT_RD))
        begin
            ov_next = 1'b0;
        end
    end
endmodule

@@ design/ims_store.sv @@
// Element buffer with one write port and one registered read port.
module ims_store (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ims_pkg::AW-1:0]    waddr,
    input  logic [31:0]               wdata,
    input  logic [ims_pkg::AW-1:0]    raddr,
    output logic [31:0]               rdata
);
    logic [31:0] mem [ims_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/ims_checker.sv @@
// Port-level assertions for the in-place merge sorter, bound to the top level.
module ims_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] sorted_value,
    input logic        end_of_set
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_value))
        else $error("stalled result changed");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall || end_of_set)
        else $error("request taken while emitting");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !end_of_set ##1 out_valid
        |-> $signed(sorted_value) >= $signed($past(sorted_value)))
        else $error("results not ascending");
endmodule

bind inplace_merge_sorter ims_checker u_ims_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .sorted_value(sorted_value), .end_of_set(end_of_set)
);

@@ tb/sv/tb.sv @@
// Testbench for the in-place merge sorter: directed and random sets checked against a sorting predictor.
`timescale 1ns / 100ps
module tb;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] value = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] sorted_value;
    logic end_of_set;

    typedef struct packed {
        logic signed [31:0] value;
        logic last;
    } request_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic end_of_set;
    } sorted_t;

    request_t pending_requests[$];
    sorted_t expected_sorted[$];
    logic signed [31:0] held_set[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int sets_sorted = 0;
    int results_seen = 0;
    int requests_sent = 0;
    bit hold_send = 1'b0;

    inplace_merge_sorter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .value(value), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .sorted_value(sorted_value), .end_of_set(end_of_set)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // stable insertion sort of the held set, queued as expected results
    task automatic sort_held_set();
        logic signed [31:0] ordered[$];
        sorted_t r;
        int k;
        ordered = {};
        foreach (held_set[i])
        begin
            k = ordered.size();
            while (k > 0 && held_set[i] < ordered[k - 1])
                k--;
            ordered.insert(k, held_set[i]);
        end
        foreach (ordered[i])
        begin
            r.sorted_value = ordered[i];
            r.end_of_set = (i == ordered.size() - 1);
            expected_sorted.push_back(r);
        end
        held_set = {};
        sets_sorted++;
    endtask

    task automatic predict(input request_t q);
        if (held_set.size() < ims_pkg::DEPTH)
            held_set.push_back(q.value);
        if (q.last)
            sort_held_set();
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 6)) - 32'sd3);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic add_set(input int n, input bit random_vals, input logic signed [31:0] base);
        request_t q;
        for (int i = 0; i < n; i++)
        begin
            q.value = random_vals ? rand_value() : base;
            q.last = (i == n - 1);
            pending_requests.push_back(q);
        end
    endtask

    // driver: hold payload while stalled, advance on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict('{value, last});
                requests_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() > 0 && !hold_send
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    request_t q;
                    q = pending_requests.pop_front();
                    value <= q.value;
                    last <= q.last;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_sorted.size() == 0)
                    report("unexpected result", sorted_value, 0);
                else
                begin
                    sorted_t e;
                    e = expected_sorted.pop_front();
                    if (sorted_value !== e.sorted_value)
                        report("sorted_value", sorted_value, e.sorted_value);
                    if (end_of_set !== e.end_of_set)
                        report("end_of_set", end_of_set, e.end_of_set);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic drain();
        while (pending_requests.size() > 0 || in_valid || expected_sorted.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        // directed: single element, extremes, duplicates, alternating extremes
        add_set(1, 1'b0, 32'sh8000_0000);
        add_set(1, 1'b0, 32'sh7fff_ffff);
        add_set(3, 1'b0, -32'sd5);
        for (int i = 0; i < 6; i++)
        begin
            request_t q;
            q.value = (i % 2) ? 32'sh8000_0000 + i : 32'sh7fff_ffff - i;
            q.last = (i == 5);
            pending_requests.push_back(q);
        end
        add_set(2, 1'b1, 0);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drain();
        // pause until all results are back, then overfill the store
        hold_send = 1'b1;
        add_set(ims_pkg::DEPTH + 3, 1'b1, 0);
        repeat (20) @(posedge clk);
        hold_send = 1'b0;
        drain();
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 26 : 0;
            for (int s = 0; s < 2; s++)
                add_set($urandom_range(1, 8), 1'b1, 0);
            drain();
        end
        recv_idle_pct = 0;
        repeat (200) @(posedge clk);
        $display("tb: %0d requests sent, %0d sets sorted, %0d results checked",
                 requests_sent, sets_sorted, results_seen);
        $display("tb: covered extremes, duplicates, overfull store and random stalls");
        if (error_count == 0 && expected_sorted.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
